@@ sv/sitda_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_pkg: shared constants and helpers for the decimal text converter
// Widths of the binary and BCD registers, ASCII codes and the BCD digit
// correction used by the shift-and-add-3 conversion.
// ----------------------------------------------------------------------------
package sitda_pkg;

	localparam int VALUE_BITS = 32;
	localparam int DIGITS     = (VALUE_BITS * 302) / 1000 + 1;
	localparam int BCD_W      = 4 * DIGITS;
	localparam int BIT_CNT_W  = $clog2(VALUE_BITS);
	localparam int DIG_CNT_W  = $clog2(DIGITS);

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_CONV = 5'b00010,
		ST_SKIP = 5'b00100,
		ST_SIGN = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

	function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] bcd);
		logic [BCD_W-1:0] res;
		logic [3:0]       d;
		res = bcd;
		for (int i = 0; i < DIGITS; i++) begin
			d = bcd[4*i +: 4];
			res[4*i +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
		end
		return res;
	endfunction

	function automatic logic bcd_valid(input logic [BCD_W-1:0] bcd);
		logic ok;
		ok = 1'b1;
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd[4*i +: 4] > 4'd9) begin
				ok = 1'b0;
			end
		end
		return ok;
	endfunction

endpackage

@@ sv/signed_int_to_decimal_ascii_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top: signed integer to decimal ASCII text
// Takes a two's-complement value on the input channel and returns its
// decimal text one character per output request, most significant first.
// A negative value opens with '-'; the final character carries last = 1.
// Zero gives the single character '0'.
//
// The magnitude goes through a bit-serial shift-and-add-3 pass, one binary
// bit per cycle over all VALUE_BITS bits. Leading zero digits are then dropped
// one digit per cycle, and the sign and digits leave one per cycle through
// an output register whenever that register is free to take the next one.
// in_ready is high only while no request is in work; the last character of
// one request may still wait in the output register while the next starts.
// A stalled receiver holds the output register and halts emission.
// Reset clears the control state and drops any request in work.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  character,
	output logic        last
);

	sitda_pkg::state_t                  state_q;
	logic [sitda_pkg::VALUE_BITS-1:0]   mag_q;
	logic [sitda_pkg::BCD_W-1:0]        bcd_q;
	logic [sitda_pkg::BIT_CNT_W-1:0]    bit_cnt_q;
	logic [sitda_pkg::DIG_CNT_W-1:0]    dig_cnt_q;
	logic                               neg_q;
	logic                               out_valid_q;
	logic [7:0]                         char_q;
	logic                               last_q;

	logic [63:0]                        value_ext;
	logic [sitda_pkg::VALUE_BITS-1:0]   raw;
	logic                               raw_neg;
	logic [sitda_pkg::VALUE_BITS-1:0]   raw_mag;
	logic [3:0]                         top_digit;
	logic [sitda_pkg::BCD_W-1:0]        bcd_adj;
	logic                               slot_free;
	logic                               out_load;
	logic                               in_fire;

	assign value_ext = {{32{value[31]}}, value};
	assign raw       = value_ext[sitda_pkg::VALUE_BITS-1:0];
	assign raw_neg   = raw[sitda_pkg::VALUE_BITS-1];
	assign raw_mag   = raw_neg ? (~raw + 1'b1) : raw;
	assign top_digit = bcd_q[sitda_pkg::BCD_W-1 -: 4];
	assign bcd_adj   = sitda_pkg::bcd_adjust(bcd_q);
	assign slot_free = !out_valid_q || out_ready;
	assign out_load  = slot_free &&
		(state_q == sitda_pkg::ST_SIGN || state_q == sitda_pkg::ST_EMIT);
	assign in_ready  = (state_q == sitda_pkg::ST_IDLE);
	assign in_fire   = in_valid && in_ready;

	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last      = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sitda_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			bit_cnt_q   <= '0;
			dig_cnt_q   <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				sitda_pkg::ST_IDLE: begin
					if (in_valid) begin
						bit_cnt_q <= sitda_pkg::BIT_CNT_W'(sitda_pkg::VALUE_BITS - 1);
						state_q   <= sitda_pkg::ST_CONV;
					end
				end
				sitda_pkg::ST_CONV: begin
					bit_cnt_q <= bit_cnt_q - 1'b1;
					if (bit_cnt_q == '0) begin
						dig_cnt_q <= sitda_pkg::DIG_CNT_W'(sitda_pkg::DIGITS - 1);
						state_q   <= sitda_pkg::ST_SKIP;
					end
				end
				sitda_pkg::ST_SKIP: begin
					if (top_digit == 4'd0 && dig_cnt_q != '0) begin
						dig_cnt_q <= dig_cnt_q - 1'b1;
					end else begin
						state_q <= neg_q ? sitda_pkg::ST_SIGN : sitda_pkg::ST_EMIT;
					end
				end
				sitda_pkg::ST_SIGN: begin
					if (slot_free) begin
						state_q <= sitda_pkg::ST_EMIT;
					end
				end
				sitda_pkg::ST_EMIT: begin
					if (slot_free) begin
						dig_cnt_q <= dig_cnt_q - 1'b1;
						if (dig_cnt_q == '0) begin
							state_q <= sitda_pkg::ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= sitda_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			sitda_pkg::ST_IDLE: begin
				if (in_valid) begin
					mag_q <= raw_mag;
					neg_q <= raw_neg;
					bcd_q <= '0;
				end
			end
			sitda_pkg::ST_CONV: begin
				bcd_q <= {bcd_adj[sitda_pkg::BCD_W-2:0], mag_q[sitda_pkg::VALUE_BITS-1]};
				mag_q <= mag_q << 1;
			end
			sitda_pkg::ST_SKIP: begin
				if (top_digit == 4'd0 && dig_cnt_q != '0) begin
					bcd_q <= bcd_q << 4;
				end
			end
			sitda_pkg::ST_SIGN: begin
				if (slot_free) begin
					char_q <= sitda_pkg::CHAR_MINUS;
					last_q <= 1'b0;
				end
			end
			sitda_pkg::ST_EMIT: begin
				if (slot_free) begin
					char_q <= sitda_pkg::CHAR_ZERO + {4'd0, top_digit};
					last_q <= (dig_cnt_q == '0);
					bcd_q  <= bcd_q << 4;
				end
			end
			default: begin
				bcd_q <= bcd_q;
			end
		endcase
	end

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && char_q == sitda_pkg::CHAR_MINUS |-> !last_q)
		else $error("sign character flagged as last");

	a_accept_starts_conv: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q == sitda_pkg::ST_CONV)
		else $error("accepted request did not start conversion");

	a_bcd_digits: assert property (@(posedge clk) disable iff (!arst_n)
		$past(in_fire) && state_q != sitda_pkg::ST_IDLE |-> sitda_pkg::bcd_valid(bcd_q))
		else $error("BCD digit out of range");

endmodule

@@ tb/sv/tb_signed_int_to_decimal_ascii_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signed_int_to_decimal_ascii_top: checks the signed integer to text path
// Sends signed 32-bit values (corner values first, then random values of
// every digit count and sign) and works out the decimal ASCII text of each
// accepted request. Each returned character and last flag is compared in
// order against that text. Both channels idle and stall at random; the
// receiver also holds off for a long stretch while requests keep coming.
// ----------------------------------------------------------------------------
module tb_signed_int_to_decimal_ascii_top;

	typedef struct {
		logic [7:0] ch;
		logic       lst;
	} text_char_t;

	class decimal_text_board;
		text_char_t expected_text[$];
		int         errors = 0;

		task report(input string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		function void note_value(input logic [31:0] v);
			logic [31:0] mag;
			logic [7:0]  digs[$];
			text_char_t  c;
			mag = v[31] ? (~v + 32'd1) : v;
			do begin
				digs.push_back(sitda_pkg::CHAR_ZERO + 8'(mag % 32'd10));
				mag = mag / 32'd10;
			end while (mag != 32'd0);
			if (v[31]) begin
				c.ch  = sitda_pkg::CHAR_MINUS;
				c.lst = 1'b0;
				expected_text.push_back(c);
			end
			for (int k = digs.size() - 1; k >= 0; k--) begin
				c.ch  = digs[k];
				c.lst = (k == 0);
				expected_text.push_back(c);
			end
		endfunction

		task check_char(input logic [7:0] ch, input logic lst);
			text_char_t e;
			if (expected_text.size() == 0) begin
				report($sformatf("unexpected character %h last %b", ch, lst));
			end else begin
				e = expected_text.pop_front();
				if (ch !== e.ch)
					report($sformatf("character got %h expected %h", ch, e.ch));
				if (lst !== e.lst)
					report($sformatf("last got %b expected %b on %h", lst, e.lst, e.ch));
			end
		endtask

		function int pending();
			return expected_text.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] value;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  character;
	logic        last;

	decimal_text_board board = new();

	int rx_hold   = 0;
	bit rx_steady = 1'b0;

	logic [31:0] corner_values[20] = '{
		32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0009,
		32'h0000_000A, 32'hFFFF_FFF6, 32'h0000_0063, 32'h0000_0064,
		32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'h3B9A_CA00,
		32'h3B9A_C9FF, 32'hC465_3601, 32'h5555_5555, 32'hAAAA_AAAA,
		32'h075B_CD15, 32'hF8A4_32EB, 32'h000F_4240, 32'hFFFF_FFF7
	};

	signed_int_to_decimal_ascii_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.character (character),
		.last      (last)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				board.note_value(value);
			if (out_valid && out_ready)
				board.check_char(character, last);
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	function automatic logic [31:0] random_value();
		longint lo;
		longint hi;
		longint mag;
		int     n;
		if ($urandom_range(0, 3) == 0)
			return $urandom;
		n  = $urandom_range(1, 10);
		lo = 1;
		for (int i = 1; i < n; i++)
			lo = lo * 10;
		hi  = (n == 10) ? 64'd2147483647 : lo * 10 - 1;
		if (n == 1)
			lo = 0;
		mag = $urandom_range(32'(hi), 32'(lo));
		if ($urandom_range(0, 1) == 1)
			return 32'(-mag);
		return 32'(mag);
	endfunction

	task automatic send_value(input logic [31:0] v, input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			value    <= $urandom;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		value    <= v;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic wait_for_text();
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		value     = 32'h0;
		out_ready = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (corner_values[i])
			send_value(corner_values[i], pick_gap());
		in_valid <= 1'b0;
		@(posedge clk);
		wait_for_text();

		repeat (40) send_value(random_value(), pick_gap());

		rx_steady = 1'b1;
		repeat (15) send_value(random_value(), 0);
		rx_steady = 1'b0;

		rx_hold = 300;
		repeat (8) send_value(random_value(), 0);

		repeat (17) send_value(random_value(), pick_gap());
		in_valid <= 1'b0;

		wait_for_text();
		repeat (64) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		int k;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_hold > 0) begin
				out_ready <= 1'b0;
				repeat (rx_hold) @(posedge clk);
				rx_hold = 0;
			end else if (rx_steady) begin
				out_ready <= 1'b1;
				@(posedge clk);
			end else begin
				k = pick_gap();
				if (k > 0) begin
					out_ready <= 1'b0;
					repeat (k) @(posedge clk);
				end
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/sitda_pkg.sv
sv/signed_int_to_decimal_ascii_top.sv
tb/sv/tb_signed_int_to_decimal_ascii_top.sv
